// ===== hw/rtl/gpeg_pkg.sv =====
package gpeg_pkg;

   localparam int PAD_COUNT    = 16;
   localparam int BUTTON_COUNT = 32;
   localparam int PAD_IDX_W    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

   localparam logic [31:0] BUTTON_MASK =
      (BUTTON_COUNT >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << BUTTON_COUNT) - 64'd1);

   localparam int AXIS_COUNT = 6;

   // serial divider geometry: |pos - min| * 200 over |max - min|
   localparam int DIVIDEND_W = 24;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
   localparam int VALUE_W    = DIVIDEND_W + 2;

   localparam logic [7:0] NORM_SCALE  = 8'd200;
   localparam int         NORM_OFFSET = 100;

   // pending event slots in emission order
   localparam int SLOT_COUNT  = 2 * AXIS_COUNT + 1 + 32;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int HAT_SLOT    = 2 * AXIS_COUNT;
   localparam int BUTTON_SLOT = HAT_SLOT + 1;

   localparam logic [1:0] CSR_AXIS_MIN     = 2'd0;
   localparam logic [1:0] CSR_AXIS_MAX     = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd2;
   localparam logic [1:0] CSR_EXTRA_ENABLE = 2'd3;

   localparam logic [5:0] CODE_X_NEG       = 6'd0;
   localparam logic [5:0] CODE_Y_NEG       = 6'd2;
   localparam logic [5:0] CODE_Z_NEG       = 6'd41;
   localparam logic [5:0] CODE_R_NEG       = 6'd43;
   localparam logic [5:0] CODE_U_NEG       = 6'd45;
   localparam logic [5:0] CODE_V_NEG       = 6'd47;
   localparam logic [5:0] CODE_BUTTON_BASE = 6'd8;
   localparam logic [5:0] CODE_HAT_LEFT    = 6'd4;
   localparam logic [5:0] CODE_HAT_RIGHT   = 6'd5;
   localparam logic [5:0] CODE_HAT_UP      = 6'd6;
   localparam logic [5:0] CODE_HAT_DOWN    = 6'd7;
   localparam logic [5:0] CODE_HAT_DL      = 6'd49;
   localparam logic [5:0] CODE_HAT_DR      = 6'd50;
   localparam logic [5:0] CODE_HAT_UL      = 6'd51;
   localparam logic [5:0] CODE_HAT_UR      = 6'd52;

   localparam logic [3:0] HAT_CENTER = 4'd0;

   typedef struct packed {
      logic [2*AXIS_COUNT-1:0] axis_lat;
      logic [3:0]              hat_dir;
      logic [31:0]             buttons;
   } pad_state_type;

   function automatic logic [5:0] axis_neg_code(input logic [2:0] axis);
      logic [5:0] code;
      unique case (axis)
         3'd0:    code = CODE_X_NEG;
         3'd1:    code = CODE_Y_NEG;
         3'd2:    code = CODE_Z_NEG;
         3'd3:    code = CODE_R_NEG;
         3'd4:    code = CODE_U_NEG;
         default: code = CODE_V_NEG;
      endcase
      return code;
   endfunction

   // 1..8 clockwise from up, centered for any other angle
   function automatic logic [3:0] hat_decode(input logic [15:0] angle);
      logic [3:0] dir;
      unique case (angle)
         16'd0:     dir = 4'd1;
         16'd4500:  dir = 4'd2;
         16'd9000:  dir = 4'd3;
         16'd13500: dir = 4'd4;
         16'd18000: dir = 4'd5;
         16'd22500: dir = 4'd6;
         16'd27000: dir = 4'd7;
         16'd31500: dir = 4'd8;
         default:   dir = HAT_CENTER;
      endcase
      return dir;
   endfunction

   function automatic logic [5:0] hat_code(input logic [3:0] dir);
      logic [5:0] code;
      unique case (dir)
         4'd1:    code = CODE_HAT_UP;
         4'd2:    code = CODE_HAT_UR;
         4'd3:    code = CODE_HAT_RIGHT;
         4'd4:    code = CODE_HAT_DR;
         4'd5:    code = CODE_HAT_DOWN;
         4'd6:    code = CODE_HAT_DL;
         4'd7:    code = CODE_HAT_LEFT;
         default: code = CODE_HAT_UL;
      endcase
      return code;
   endfunction

   function automatic logic [5:0] slot_code(input logic [SLOT_W-1:0] slot,
                                            input logic [5:0] hat_cd);
      logic [5:0] code;
      if (slot < SLOT_W'(HAT_SLOT)) begin
         code = axis_neg_code(3'(slot >> 1)) + 6'(slot[0]);
      end else if (slot == SLOT_W'(HAT_SLOT)) begin
         code = hat_cd;
      end else begin
         code = CODE_BUTTON_BASE + 6'(slot - SLOT_W'(BUTTON_SLOT));
      end
      return code;
   endfunction

endpackage

// ===== hw/rtl/gpeg_divider.sv =====
module gpeg_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gpeg_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [gpeg_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              busy,
   output logic                              done,
   output logic [gpeg_pkg::DIVIDEND_W-1:0]   quotient
);

   logic [gpeg_pkg::DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [gpeg_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [gpeg_pkg::DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [gpeg_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [gpeg_pkg::DIVISOR_W:0]    shifted;
   logic [gpeg_pkg::DIVISOR_W+1:0]  trial;

   // one restoring step per cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[gpeg_pkg::DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = gpeg_pkg::DIV_CNT_W'(gpeg_pkg::DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[gpeg_pkg::DIVISOR_W+1]) begin
            rem_in  = trial[gpeg_pkg::DIVISOR_W-1:0];
            quot_in = {quot_ff[gpeg_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[gpeg_pkg::DIVISOR_W-1:0];
            quot_in = {quot_ff[gpeg_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == gpeg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== hw/rtl/gpeg_pad_state.sv =====
module gpeg_pad_state (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [gpeg_pkg::PAD_IDX_W-1:0]  idx,
   input  logic                            wr_en,
   input  gpeg_pkg::pad_state_type         wr_data,
   output gpeg_pkg::pad_state_type         rd_data
);

   gpeg_pkg::pad_state_type pads_ff [gpeg_pkg::PAD_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gpeg_pkg::PAD_COUNT; i++) begin
            pads_ff[i] <= '0;
         end
      end else if (wr_en) begin
         pads_ff[idx] <= wr_data;
      end
   end

   assign rd_data = pads_ff[idx];

endmodule

// ===== hw/rtl/gamepad_poll_event_generator.sv =====
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  pad index, poll flag, six axes, hat, buttons
// rsp      out        rsp_valid/rsp_stall  pad, control code, last flag
// csr      in         csr_valid/csr_ready  2-bit register index, 16-bit data
// an accepted item loads its pad state, then takes each axis in turn: a checked axis with a
// nonempty range runs through the shared one-bit-per-cycle divider, one with an empty range
// compares as zero, any other axis is skipped; then hat and buttons are handled, events emitted
// a failed poll is taken and dropped without leaving idle
// reset is synchronous and clears the state, CSR and pending-event registers and every pad's latches
// rsp_stall holds the current event; req_stall stays high until the last event is taken
module gamepad_poll_event_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_joystick_index,
   input  logic        req_poll_valid,
   input  logic [15:0] req_x_pos,
   input  logic [15:0] req_y_pos,
   input  logic [15:0] req_z_pos,
   input  logic [15:0] req_r_pos,
   input  logic [15:0] req_u_pos,
   input  logic [15:0] req_v_pos,
   input  logic [15:0] req_hat_angle,
   input  logic [31:0] req_button_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_joystick,
   output logic [5:0]  rsp_event_control,
   output logic        rsp_event_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_AXIS,
      S_DIV,
      S_HAT,
      S_EMIT
   } state_type;

   localparam int LAT_W = 2 * gpeg_pkg::AXIS_COUNT;
   localparam int VW    = gpeg_pkg::VALUE_W;
   localparam int SC    = gpeg_pkg::SLOT_COUNT;
   localparam int SW    = gpeg_pkg::SLOT_W;

   state_type   state_ff;
   logic [15:0] axis_min_ff;
   logic [15:0] axis_max_ff;
   logic [6:0]  thr_ff;
   logic [3:0]  extra_en_ff;

   logic [3:0]  pad_ff;
   logic [15:0] pos_ff [gpeg_pkg::AXIS_COUNT];
   logic [15:0] hat_ff;
   logic [31:0] btn_ff;
   logic [2:0]  axis_ff;
   logic [LAT_W-1:0] lat_ff;
   logic [SC-1:0]    pend_ff;
   logic             qneg_ff;
   logic [5:0]       hatcode_ff;
   logic             rsp_valid_ff;
   logic [5:0]       rsp_code_ff;
   logic             rsp_last_ff;

   logic        req_accept;
   logic        rsp_accept;
   logic        pad_ok;
   logic        axis_en;
   logic [16:0] diff;
   logic [16:0] span;
   logic [15:0] diff_mag;
   logic [15:0] span_mag;

   logic                               div_start;
   logic                               div_busy;
   logic                               div_done;
   logic [gpeg_pkg::DIVIDEND_W-1:0]    div_dividend;
   logic [gpeg_pkg::DIVIDEND_W-1:0]    div_quot;

   logic signed [VW-1:0] q_signed;
   logic signed [VW-1:0] v_div;
   logic signed [VW-1:0] v_sel;
   logic signed [VW-1:0] thr_s;
   logic                 is_neg;
   logic                 is_pos;
   logic [LAT_W-1:0]     lat_upd;
   logic [SC-1:0]        pend_axis;
   logic                 cmp_now;

   logic [3:0]    new_dir;
   logic [31:0]   btn_masked;
   logic [SC-1:0] pend_hat;

   logic [SC-1:0] low_oh;
   logic [SC-1:0] pend_rest;
   logic [SW-1:0] low_idx;

   gpeg_pkg::pad_state_type st_rd;
   gpeg_pkg::pad_state_type st_wr;
   logic                    st_wr_en;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign pad_ok     = req_poll_valid &&
                       ({1'b0, req_joystick_index} < 5'(gpeg_pkg::PAD_COUNT));

   gpeg_pad_state u_pad_state (
      .clock   (clock),
      .reset   (reset),
      .idx     (pad_ff[gpeg_pkg::PAD_IDX_W-1:0]),
      .wr_en   (st_wr_en),
      .wr_data (st_wr),
      .rd_data (st_rd)
   );

   // axis setup
   always_comb begin
      axis_en  = (axis_ff < 3'd2) || extra_en_ff[2'(axis_ff - 3'd2)];
      diff     = {1'b0, pos_ff[axis_ff]} - {1'b0, axis_min_ff};
      span     = {1'b0, axis_max_ff} - {1'b0, axis_min_ff};
      diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
      span_mag = span[16] ? 16'(-span) : span[15:0];
      div_dividend = gpeg_pkg::DIVIDEND_W'(diff_mag) *
                     gpeg_pkg::DIVIDEND_W'(gpeg_pkg::NORM_SCALE);
      div_start    = (state_ff == S_AXIS) && axis_en && (span != '0);
   end

   gpeg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (span_mag),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // threshold compare and latch update for the current axis
   always_comb begin
      q_signed = signed'({2'b00, div_quot});
      if (qneg_ff) begin
         q_signed = -q_signed;
      end
      v_div = q_signed - VW'(gpeg_pkg::NORM_OFFSET);
      v_sel = (state_ff == S_DIV) ? v_div : '0;
      thr_s = signed'(VW'(thr_ff));
      is_neg = v_sel < -thr_s;
      is_pos = v_sel > thr_s;
      pend_axis = '0;
      pend_axis[{axis_ff, 1'b0}] = is_neg && !lat_ff[{axis_ff, 1'b0}];
      pend_axis[{axis_ff, 1'b1}] = is_pos && !lat_ff[{axis_ff, 1'b1}];
      lat_upd = lat_ff;
      lat_upd[{axis_ff, 1'b0}] = is_neg;
      lat_upd[{axis_ff, 1'b1}] = is_pos;
      cmp_now = ((state_ff == S_DIV) && div_done) ||
                ((state_ff == S_AXIS) && axis_en && (span == '0));
   end

   // hat and buttons
   always_comb begin
      new_dir    = gpeg_pkg::hat_decode(hat_ff);
      btn_masked = btn_ff & gpeg_pkg::BUTTON_MASK;
      pend_hat   = '0;
      pend_hat[gpeg_pkg::HAT_SLOT] = (new_dir != gpeg_pkg::HAT_CENTER) &&
                                     (new_dir != st_rd.hat_dir);
      pend_hat[SC-1:gpeg_pkg::BUTTON_SLOT] = btn_masked & ~st_rd.buttons;
      st_wr.axis_lat = lat_ff;
      st_wr.hat_dir  = new_dir;
      st_wr.buttons  = btn_masked;
      st_wr_en       = (state_ff == S_HAT);
   end

   // lowest pending event goes out first
   always_comb begin
      low_oh    = pend_ff & (~pend_ff + 1'b1);
      pend_rest = pend_ff & ~low_oh;
      low_idx   = '0;
      for (int i = 0; i < SC; i++) begin
         if (low_oh[i]) begin
            low_idx = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_min_ff  <= 16'd0;
         axis_max_ff  <= 16'hFFFF;
         thr_ff       <= 7'd60;
         extra_en_ff  <= 4'd0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               gpeg_pkg::CSR_AXIS_MIN:     axis_min_ff <= csr_data;
               gpeg_pkg::CSR_AXIS_MAX:     axis_max_ff <= csr_data;
               gpeg_pkg::CSR_THRESHOLD:    thr_ff      <= csr_data[6:0];
               gpeg_pkg::CSR_EXTRA_ENABLE: extra_en_ff <= csr_data[3:0];
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept && pad_ok) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               lat_ff   <= st_rd.axis_lat;
               axis_ff  <= '0;
               pend_ff  <= '0;
               state_ff <= S_AXIS;
            end
            S_AXIS, S_DIV: begin
               if (div_start) begin
                  qneg_ff  <= diff[16] ^ span[16];
                  state_ff <= S_DIV;
               end else if (cmp_now || (state_ff == S_AXIS)) begin
                  if (cmp_now) begin
                     lat_ff  <= lat_upd;
                     pend_ff <= pend_ff | pend_axis;
                  end
                  if (axis_ff == 3'(gpeg_pkg::AXIS_COUNT - 1)) begin
                     state_ff <= S_HAT;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= S_AXIS;
                  end
               end
            end
            S_HAT: begin
               pend_ff    <= pend_ff | pend_hat;
               hatcode_ff <= gpeg_pkg::hat_code(new_dir);
               state_ff   <= ((pend_ff | pend_hat) != '0) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_accept) begin
                  if (pend_ff != '0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_code_ff  <= gpeg_pkg::slot_code(low_idx, hatcode_ff);
                     rsp_last_ff  <= (pend_rest == '0);
                     pend_ff      <= pend_rest;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // capture the item payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pad_ff    <= req_joystick_index;
         pos_ff[0] <= req_x_pos;
         pos_ff[1] <= req_y_pos;
         pos_ff[2] <= req_z_pos;
         pos_ff[3] <= req_r_pos;
         pos_ff[4] <= req_u_pos;
         pos_ff[5] <= req_v_pos;
         hat_ff    <= req_hat_angle;
         btn_ff    <= req_button_bits;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_joystick = pad_ff;
   assign rsp_event_control  = rsp_code_ff;
   assign rsp_event_last     = rsp_last_ff;

   // no new item while events of the current one are outstanding
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("item accepted while events pending");

   // events of one item follow back to back until the last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_event_last) |=> rsp_valid)
      else $error("event stream broken before last event");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_event_last) |=> !rsp_valid)
      else $error("event after last event of item");

   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider restarted while busy");

endmodule
